### design/plid_pkg.sv
// Shared definitions for the positional list insert/delete unit.
// Holds the operation and status codes and the control bundle that is sent to the storage cells.
// No dependencies.
package plid_pkg;

    localparam int WORD_W = 32;
    localparam int POS_W  = 8;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUSY,
        S_OUT
    } state_t;

    // Control broadcast to every cell. The target is the 0-based slot of the request.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic             sel;
        logic [POS_W-1:0] tgt;
    } cell_ctl_t;

endpackage

### design/plid_cell.sv
// One storage slot of the positional list.
// Shifts toward higher or lower slots on insert and delete; uses plid_pkg.
module plid_cell #(
    parameter int IDX = 0
) (
    input  logic                         clk,
    input  plid_pkg::cell_ctl_t          ctl,
    input  logic signed [plid_pkg::WORD_W-1:0] left_word,
    input  logic signed [plid_pkg::WORD_W-1:0] right_word,
    input  logic signed [plid_pkg::WORD_W-1:0] ins_word,
    output logic signed [plid_pkg::WORD_W-1:0] word,
    output logic signed [plid_pkg::WORD_W-1:0] sel_word
);
    import plid_pkg::*;

    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] word_next;
    logic                     above_tgt;
    logic                     at_tgt;

    assign above_tgt = IDX > int'(ctl.tgt);
    assign at_tgt    = IDX == int'(ctl.tgt);

    always_comb
    begin
        word_next = word_reg;
        if (ctl.ins)
        begin
            if (above_tgt)
                word_next = left_word;
            else if (at_tgt)
                word_next = ins_word;
        end
        else if (ctl.del)
        begin
            if (above_tgt || at_tgt)
                word_next = right_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word     = word_reg;
    assign sel_word = (ctl.sel && at_tgt) ? word_reg : '0;

endmodule

### design/plid_or_tree.sv
// Registered OR reduction that gathers the one selected cell word.
// Every tree level is a register stage. Uses plid_pkg.
module plid_or_tree #(
    parameter int LEAVES = 128
) (
    input  logic                                clk,
    input  logic signed [plid_pkg::WORD_W-1:0]  leaf [LEAVES],
    output logic signed [plid_pkg::WORD_W-1:0]  root
);
    import plid_pkg::*;

    localparam int LVLS = (LEAVES > 1) ? $clog2(LEAVES) : 1;
    localparam int PAD  = 1 << LVLS;

    logic signed [WORD_W-1:0] leaf_pad [PAD];
    logic signed [WORD_W-1:0] node_reg [1:PAD-1];

    genvar i;
    generate
        for (i = 0; i < PAD; i++)
        begin : g_pad
            if (i < LEAVES)
            begin : g_real
                assign leaf_pad[i] = leaf[i];
            end
            else
            begin : g_zero
                assign leaf_pad[i] = '0;
            end
        end

        // Heap order: node n has children 2n and 2n+1; indexes from PAD up are leaves.
        for (i = 1; i < PAD; i++)
        begin : g_node
            if (2 * i >= PAD)
            begin : g_bottom
                always_ff @(posedge clk)
                begin
                    node_reg[i] <= leaf_pad[2*i-PAD] | leaf_pad[2*i+1-PAD];
                end
            end
            else
            begin : g_inner
                always_ff @(posedge clk)
                begin
                    node_reg[i] <= node_reg[2*i] | node_reg[2*i+1];
                end
            end
        end
    endgenerate

    assign root = node_reg[1];

endmodule

### design/positional_list_insert_delete_unit.sv
// Positional list of signed 32-bit words held in a row of shifting cells. Each request inserts
// a word at a 1-based position, deletes the word at a position, or reads it. Insert and delete
// move all trailing cells in the cycle the request is accepted; the word returned by a read or
// delete is gathered by a registered OR tree of clog2(CAPACITY) stages. The result is offered
// once the tree root is registered at the end of S_BUSY; when it is taken, the unit returns to
// S_IDLE and can accept the next request, so it works on one request at a time. Stored words
// are not reset.
module positional_list_insert_delete_unit #(
    parameter int CAPACITY = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          func,
    input  logic [plid_pkg::POS_W-1:0]          position,
    input  logic signed [plid_pkg::WORD_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          status,
    output logic signed [plid_pkg::WORD_W-1:0]  data_out,
    output logic [7:0]                          count
);
    import plid_pkg::*;

    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CMP_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int TREE_LVLS = $clog2(CAPACITY);
    localparam int LVL_W     = $clog2(TREE_LVLS + 1);

    state_t                   state_reg, state_next;
    logic [LVL_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         elem_cnt_reg, elem_cnt_next;
    status_t                  status_reg, status_next;
    logic [7:0]               count_reg;
    logic signed [WORD_W-1:0] data_reg;

    logic                     accept;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         cnt_ext;
    logic                     ins_pos_ok;
    logic                     acc_pos_ok;
    logic                     full;
    cell_ctl_t                ctl;

    logic signed [WORD_W-1:0] cell_word [CAPACITY];
    logic signed [WORD_W-1:0] sel_word  [CAPACITY];
    logic signed [WORD_W-1:0] root;

    assign accept  = in_valid && in_ready;
    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(elem_cnt_reg);

    assign ins_pos_ok = (position != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
    assign acc_pos_ok = (position != '0) && (pos_ext <= cnt_ext);
    assign full       = elem_cnt_reg == CNT_W'(CAPACITY);

    always_comb
    begin
        ctl.ins = accept && (func == OP_INSERT) && ins_pos_ok && !full;
        ctl.del = accept && (func == OP_DELETE) && acc_pos_ok;
        ctl.sel = ((func == OP_DELETE) || (func == OP_READ)) && acc_pos_ok;
        ctl.tgt = position - POS_W'(1);
    end

    always_comb
    begin
        status_next   = ST_BADPOS;
        elem_cnt_next = elem_cnt_reg;
        unique case (func)
            OP_INSERT:
            begin
                if (ins_pos_ok)
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        status_next   = ST_OK;
                        elem_cnt_next = elem_cnt_reg + CNT_W'(1);
                    end
                end
            end
            OP_DELETE:
            begin
                if (acc_pos_ok)
                begin
                    status_next   = ST_OK;
                    elem_cnt_next = elem_cnt_reg - CNT_W'(1);
                end
            end
            OP_READ:
            begin
                if (acc_pos_ok)
                    status_next = ST_OK;
            end
            default:
            begin
                status_next = ST_BADPOS;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [WORD_W-1:0] left_w;
            logic signed [WORD_W-1:0] right_w;

            if (g == 0)
            begin : g_first
                assign left_w = '0;
            end
            else
            begin : g_left
                assign left_w = cell_word[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign right_w = '0;
            end
            else
            begin : g_right
                assign right_w = cell_word[g+1];
            end

            plid_cell #(
                .IDX (g)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .left_word  (left_w),
                .right_word (right_w),
                .ins_word   (value),
                .word       (cell_word[g]),
                .sel_word   (sel_word[g])
            );
        end
    endgenerate

    // The tree samples the cells at the accepting edge, before any shift lands.
    plid_or_tree #(
        .LEAVES (CAPACITY)
    ) u_tree (
        .clk  (clk),
        .leaf (sel_word),
        .root (root)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_BUSY;
            end
            S_BUSY:
            begin
                if (cnt_reg == '0)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
            cnt_next = LVL_W'(TREE_LVLS - 1);
        else if ((state_reg == S_BUSY) && (cnt_reg != '0))
            cnt_next = cnt_reg - LVL_W'(1);
    end

    always_comb
    begin
        in_ready  = state_reg == S_IDLE;
        out_valid = state_reg == S_OUT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            elem_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            if (accept)
                elem_cnt_reg <= elem_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            count_reg  <= 8'(elem_cnt_next);
        end
        if ((state_reg == S_BUSY) && (cnt_reg == '0))
            data_reg <= root;
    end

    assign status   = status_reg;
    assign count    = count_reg;
    assign data_out = data_reg;

endmodule
